### hdl/mic_pkg.sv
// Package with shared types, constants and helper functions for the magnetometer calibration.
package mic_pkg;

    localparam int FIELD_FRAC_BITS_DEF = 16;
    localparam int SCALE_ONE = 65536;
    localparam logic [19:0] SCALE_MAX = 20'hFFFFF;
    localparam int NUM_AXES = 3;
    localparam logic [31:0] POS_MAX = 32'h7FFFFFFF;
    localparam logic [31:0] NEG_MAX = 32'h80000000;

    localparam logic [2:0] MODE_SAMPLE = 3'd0;
    localparam logic [2:0] MODE_FINISH = 3'd1;
    localparam logic [2:0] MODE_CORRECT = 3'd2;
    localparam logic [2:0] MODE_LOAD_OFF = 3'd3;
    localparam logic [2:0] MODE_LOAD_SCL = 3'd4;

    localparam logic [1:0] KIND_CORRECTED = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_RESULT = 2'd2;
    localparam logic [1:0] KIND_LOAD = 2'd3;

    localparam logic [2:0] GAIN_RESET = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_APPLY,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic correct;
    } lane_ctl_t;

    function automatic logic [10:0] gain_divisor(input logic [2:0] code);
        logic [10:0] d;
        begin
            unique case (code)
                3'd0: d = 11'd1370;
                3'd1: d = 11'd1090;
                3'd2: d = 11'd820;
                3'd3: d = 11'd660;
                3'd4: d = 11'd440;
                3'd5: d = 11'd390;
                3'd6: d = 11'd330;
                default: d = 11'd230;
            endcase
            return d;
        end
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        begin
            if (v > 64'sh7FFFFFFF) begin
                r = POS_MAX;
            end else if (v < -64'sh80000000) begin
                r = NEG_MAX;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

### hdl/mic_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module mic_divider
    import mic_pkg::*;
#(
    parameter int NUM_W = 64,
    parameter int DEN_W = 40
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [DEN_W:0] trial;

    always_comb begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        if (start) begin
            quot_next = numer;
            rem_next = '0;
            den_next = denom;
            cnt_next = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### hdl/mic_lane.sv
// One axis lane: conversion, correction and scale division.
module mic_lane
    import mic_pkg::*;
#(
    parameter int FIELD_FRAC_BITS = FIELD_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  lane_ctl_t   ctl,
    input  logic [2:0]  gain_code,
    input  logic [15:0] raw,
    input  logic [31:0] offset,
    input  logic [19:0] scale,
    input  logic        div_start,
    input  logic [63:0] div_numer,
    input  logic [39:0] div_denom,
    output logic        conv_done,
    output logic [31:0] field,
    output logic [31:0] corrected,
    output logic        div_done,
    output logic [63:0] div_quot
);

    localparam int RCP_W = FIELD_FRAC_BITS + 9;
    localparam int EP_W = RCP_W + 16;
    localparam int NUM_W = FIELD_FRAC_BITS + 17;
    localparam int PRD_W = RCP_W + 11;

    logic neg_reg;
    logic [15:0] mag_reg;
    logic [10:0] dv_reg;
    logic [RCP_W-1:0] rcp_reg;
    logic [RCP_W-1:0] est_reg;
    logic [12:0] rem_reg;
    logic [RCP_W-1:0] q_reg;
    logic s1_reg, s2_reg, s3_reg, done_reg;
    logic [31:0] corr_reg;
    logic [10:0] d;
    logic [15:0] mag;
    logic [EP_W-1:0] est_prod;
    logic [NUM_W-1:0] conv_num;
    logic [PRD_W-1:0] rem_w;
    logic [31:0] field_w;
    logic signed [33:0] diff;
    logic [32:0] dmag;
    logic [52:0] prod_reg;
    logic dneg_reg;
    logic signed [63:0] cval;

    // The reciprocal estimate is at most one below the rounded quotient.
    function automatic logic [RCP_W-1:0] recip(input logic [2:0] code);
        logic [63:0] r;
        begin
            case (code)
                3'd0: r = (64'd1 << (FIELD_FRAC_BITS + 16)) / 64'd1370;
                3'd1: r = (64'd1 << (FIELD_FRAC_BITS + 16)) / 64'd1090;
                3'd2: r = (64'd1 << (FIELD_FRAC_BITS + 16)) / 64'd820;
                3'd3: r = (64'd1 << (FIELD_FRAC_BITS + 16)) / 64'd660;
                3'd4: r = (64'd1 << (FIELD_FRAC_BITS + 16)) / 64'd440;
                3'd5: r = (64'd1 << (FIELD_FRAC_BITS + 16)) / 64'd390;
                3'd6: r = (64'd1 << (FIELD_FRAC_BITS + 16)) / 64'd330;
                default: r = (64'd1 << (FIELD_FRAC_BITS + 16)) / 64'd230;
            endcase
            return r[RCP_W-1:0];
        end
    endfunction

    assign d = gain_divisor(gain_code);
    assign mag = raw[15] ? 16'(-raw) : raw;

    assign est_prod = EP_W'(mag_reg) * EP_W'(rcp_reg);
    assign conv_num = NUM_W'({mag_reg, {FIELD_FRAC_BITS{1'b0}}}) + NUM_W'(dv_reg[10:1]);
    assign rem_w = PRD_W'(conv_num) - PRD_W'(est_reg) * PRD_W'(dv_reg);

    mic_divider #(.NUM_W(64), .DEN_W(40)) u_scale (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .numer(div_numer),
        .denom(div_denom), .done(div_done), .quot(div_quot)
    );

    assign field_w = sat32(neg_reg ? -$signed(64'(q_reg)) : $signed(64'(q_reg)));
    assign diff = $signed({{2{field_w[31]}}, field_w}) - $signed({{2{offset[31]}}, offset});
    assign dmag = diff[33] ? 33'(-diff) : diff[32:0];
    assign cval = dneg_reg ? -$signed(64'((prod_reg + 53'd32768) >> 16))
                           : $signed(64'((prod_reg + 53'd32768) >> 16));

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            neg_reg <= raw[15];
            mag_reg <= mag;
            dv_reg <= d;
            rcp_reg <= recip(gain_code);
        end
        if (s1_reg) begin
            est_reg <= est_prod[EP_W-1:16];
        end
        if (s2_reg) begin
            rem_reg <= rem_w[12:0];
        end
        if (s3_reg) begin
            q_reg <= est_reg + RCP_W'(rem_reg >= {2'b00, dv_reg});
        end
        if (ctl.correct) begin
            prod_reg <= dmag * scale;
            dneg_reg <= diff[33];
            corr_reg <= sat32(cval);
        end
        if (!aresetn) begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
            s3_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            s1_reg <= ctl.start;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            done_reg <= s3_reg;
        end
    end

    assign conv_done = done_reg;
    assign field = field_w;
    assign corrected = corr_reg;

endmodule

### hdl/magnetometer_iron_calibration.sv
// Top level of the magnetometer hard and soft iron calibration block.
// Samples and corrections pass through the lane conversion pipeline and the apply state,
// a finish that succeeds through the 64-step scale divider; loads and a finish that fails go straight to the output.
// Transactions are handled one at a time; the next input is taken in the cycle after the
// result transaction at the earliest.
// Reset: aresetn is synchronous and active low; it restores gain, offsets, scales, trackers.
module magnetometer_iron_calibration
    import mic_pkg::*;
#(
    parameter int FIELD_FRAC_BITS = FIELD_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [15:0] s_raw_x,
    input  logic [15:0] s_raw_y,
    input  logic [15:0] s_raw_z,
    input  logic [31:0] s_load_x,
    input  logic [31:0] s_load_y,
    input  logic [31:0] s_load_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_out_x,
    output logic [31:0] m_out_y,
    output logic [31:0] m_out_z,
    output logic [19:0] m_out_scale_x,
    output logic [19:0] m_out_scale_y,
    output logic [19:0] m_out_scale_z,
    output logic        m_error
);

    state_t state_reg, state_next;
    logic [2:0] gain_reg;
    logic [2:0] mode_reg;
    logic [1:0] cnt_reg;
    logic [15:0] raw_in [NUM_AXES];
    logic [31:0] load_reg [NUM_AXES];
    logic [31:0] min_reg [NUM_AXES];
    logic [31:0] max_reg [NUM_AXES];
    logic [31:0] off_reg [NUM_AXES];
    logic [19:0] scl_reg [NUM_AXES];
    logic seen_reg;
    logic [31:0] field [NUM_AXES];
    logic [31:0] corr [NUM_AXES];
    logic conv_done [NUM_AXES];
    logic div_done [NUM_AXES];
    logic [63:0] quot [NUM_AXES];
    logic [33:0] sdiff [NUM_AXES];
    logic [32:0] spread [NUM_AXES];
    logic [39:0] den [NUM_AXES];
    logic [34:0] total;
    logic [63:0] numer;
    logic fin_err;
    logic lane_go, div_go;
    lane_ctl_t ctl;
    logic mv_reg;
    logic [1:0] kind_reg;
    logic [31:0] ox_reg [NUM_AXES];
    logic err_reg;
    logic cfg_wr;
    logic [32:0] sum_w [NUM_AXES];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {29'd0, gain_reg} : 32'd0;
    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;

    assign raw_in[0] = s_raw_x;
    assign raw_in[1] = s_raw_y;
    assign raw_in[2] = s_raw_z;

    always_comb begin
        total = '0;
        fin_err = !seen_reg;
        for (int i = 0; i < NUM_AXES; i++) begin
            sdiff[i] = $signed({{2{max_reg[i][31]}}, max_reg[i]})
                       - $signed({{2{min_reg[i][31]}}, min_reg[i]});
            spread[i] = sdiff[i][32:0];
            if (sdiff[i][33] || sdiff[i] == 34'd0) begin
                fin_err = 1'b1;
            end
            total = total + 35'(spread[i]);
            den[i] = 40'(spread[i]) * 40'd3;
            sum_w[i] = 33'($signed({max_reg[i][31], max_reg[i]})
                           + $signed({min_reg[i][31], min_reg[i]}));
        end
    end

    assign numer = {13'd0, total, 16'd0};
    assign ctl.start = lane_go;
    assign ctl.correct = (mode_reg == MODE_CORRECT);

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        mic_lane #(.FIELD_FRAC_BITS(FIELD_FRAC_BITS)) u_lane (
            .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .gain_code(gain_reg),
            .raw(raw_in[g]), .offset(off_reg[g]), .scale(scl_reg[g]),
            .div_start(div_go), .div_numer(numer + 64'(den[g][39:1])),
            .div_denom(den[g]), .conv_done(conv_done[g]), .field(field[g]),
            .corrected(corr[g]), .div_done(div_done[g]), .div_quot(quot[g])
        );
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    unique case (s_mode)
                        MODE_SAMPLE, MODE_CORRECT: state_next = ST_CONV;
                        MODE_FINISH: state_next = fin_err ? ST_OUT : ST_DIV;
                        MODE_LOAD_OFF, MODE_LOAD_SCL: state_next = ST_OUT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV: if (conv_done[0]) state_next = ST_APPLY;
            ST_APPLY: if (cnt_reg == 2'd2) state_next = ST_OUT;
            ST_DIV: if (div_done[0]) state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        lane_go = (state_reg == ST_IDLE) && s_valid && s_ready
                  && (s_mode == MODE_SAMPLE || s_mode == MODE_CORRECT);
        div_go = (state_reg == ST_IDLE) && s_valid && s_ready
                 && (s_mode == MODE_FINISH) && !fin_err;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            load_reg[0] <= s_load_x;
            load_reg[1] <= s_load_y;
            load_reg[2] <= s_load_z;
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gain_reg <= GAIN_RESET;
            mode_reg <= MODE_SAMPLE;
            cnt_reg <= 2'd0;
            seen_reg <= 1'b0;
            mv_reg <= 1'b0;
            kind_reg <= KIND_CORRECTED;
            err_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                min_reg[i] <= POS_MAX;
                max_reg[i] <= NEG_MAX;
                off_reg[i] <= '0;
                scl_reg[i] <= 20'(SCALE_ONE);
                ox_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                gain_reg <= pwdata[2:0];
            end
            if (mv_reg && m_ready) begin
                mv_reg <= 1'b0;
            end
            if (state_reg == ST_APPLY) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else begin
                cnt_reg <= 2'd0;
            end
            if (state_reg == ST_IDLE && s_valid && s_ready) begin
                mode_reg <= s_mode;
                if (s_mode == MODE_FINISH) begin
                    err_reg <= fin_err;
                    if (fin_err) begin
                        for (int i = 0; i < NUM_AXES; i++) begin
                            min_reg[i] <= POS_MAX;
                            max_reg[i] <= NEG_MAX;
                        end
                        seen_reg <= 1'b0;
                    end else begin
                        for (int i = 0; i < NUM_AXES; i++) begin
                            off_reg[i] <= sum_w[i][32:1];
                        end
                    end
                end else begin
                    err_reg <= 1'b0;
                end
            end
            if (state_reg == ST_DIV && div_done[0]) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    scl_reg[i] <= (quot[i] > 64'(SCALE_MAX)) ? SCALE_MAX : quot[i][19:0];
                    min_reg[i] <= POS_MAX;
                    max_reg[i] <= NEG_MAX;
                end
                seen_reg <= 1'b0;
            end
            if (state_reg == ST_CONV && conv_done[0] && mode_reg == MODE_SAMPLE) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    if ($signed(field[i]) < $signed(min_reg[i])) min_reg[i] <= field[i];
                    if ($signed(field[i]) > $signed(max_reg[i])) max_reg[i] <= field[i];
                    ox_reg[i] <= field[i];
                end
                seen_reg <= 1'b1;
            end
            if (state_reg == ST_OUT) begin
                mv_reg <= 1'b1;
                unique case (mode_reg)
                    MODE_SAMPLE: kind_reg <= KIND_SAMPLE;
                    MODE_CORRECT: begin
                        kind_reg <= KIND_CORRECTED;
                        for (int i = 0; i < NUM_AXES; i++) ox_reg[i] <= corr[i];
                    end
                    MODE_FINISH: begin
                        kind_reg <= KIND_RESULT;
                        for (int i = 0; i < NUM_AXES; i++) ox_reg[i] <= off_reg[i];
                    end
                    MODE_LOAD_OFF: begin
                        kind_reg <= KIND_LOAD;
                        for (int i = 0; i < NUM_AXES; i++) begin
                            off_reg[i] <= load_reg[i];
                            ox_reg[i] <= load_reg[i];
                        end
                    end
                    default: begin
                        kind_reg <= KIND_LOAD;
                        for (int i = 0; i < NUM_AXES; i++) begin
                            ox_reg[i] <= off_reg[i];
                            if (load_reg[i][31]) scl_reg[i] <= '0;
                            else if (load_reg[i][30:20] != '0) scl_reg[i] <= SCALE_MAX;
                            else scl_reg[i] <= load_reg[i][19:0];
                        end
                    end
                endcase
                if (mode_reg == MODE_SAMPLE || mode_reg == MODE_CORRECT) begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        if (mode_reg == MODE_SAMPLE) ox_reg[i] <= field[i];
                    end
                end
            end
        end
    end

    assign m_valid = mv_reg;
    assign m_kind = kind_reg;
    assign m_out_x = ox_reg[0];
    assign m_out_y = ox_reg[1];
    assign m_out_z = ox_reg[2];
    assign m_out_scale_x = scl_reg[0];
    assign m_out_scale_y = scl_reg[1];
    assign m_out_scale_z = scl_reg[2];
    assign m_error = err_reg;

endmodule

### hdl/mic_checker.sv
// Port-level checker for the magnetometer calibration block and its bind.
module mic_checker
    import mic_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [2:0]  s_mode,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic        m_error,
    input logic [31:0] m_out_x
);

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    property p_err_kind;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_kind == KIND_RESULT;
    endproperty
    a_err_kind: assert property (p_err_kind) else $error("error on non-result kind");

    property p_one;
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode <= MODE_LOAD_SCL) |=> !s_ready;
    endproperty
    a_one: assert property (p_one) else $error("second transaction taken at once");

    property p_rst;
        @(posedge aclk) !aresetn |=> !m_valid;
    endproperty
    a_rst: assert property (p_rst) else $error("result valid after reset");

endmodule

bind magnetometer_iron_calibration mic_checker u_mic_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_mode(s_mode), .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
    .m_error(m_error), .m_out_x(m_out_x)
);

### test/testbench.sv
// Self-checking testbench for the magnetometer iron calibration block.
`timescale 1ns / 100ps

module testbench
    import mic_pkg::*;
;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] x, y, z;
        logic [19:0] sx, sy, sz;
        logic        err;
    } mag_result_t;

    class calib_scoreboard;
        logic [2:0]         gain;
        logic signed [31:0] tmin[3], tmax[3], offs[3];
        logic [19:0]        scl[3];
        bit                 seen;
        mag_result_t        pending[$];
        int                 errors;

        function void init();
            gain = GAIN_RESET;
            for (int i = 0; i < 3; i++) begin
                offs[i] = '0;
                scl[i] = 20'(SCALE_ONE);
            end
            clear();
            errors = 0;
        endfunction

        function void clear();
            for (int i = 0; i < 3; i++) begin
                tmin[i] = POS_MAX;
                tmax[i] = NEG_MAX;
            end
            seen = 0;
        endfunction

        function logic signed [31:0] saturate(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function logic signed [31:0] gauss(logic signed [15:0] raw);
            longint d, m, q;
            case (gain)
                3'd0: d = 1370;
                3'd1: d = 1090;
                3'd2: d = 820;
                3'd3: d = 660;
                3'd4: d = 440;
                3'd5: d = 390;
                3'd6: d = 330;
                default: d = 230;
            endcase
            m = (raw < 0) ? -longint'(raw) : longint'(raw);
            q = ((m <<< 16) + d / 2) / d;
            return saturate(raw < 0 ? -q : q);
        endfunction

        function logic signed [31:0] corrected(logic signed [31:0] f,
                                               logic signed [31:0] o, logic [19:0] s);
            longint diff, m, r;
            diff = longint'(f) - longint'(o);
            m = (diff < 0) ? -diff : diff;
            r = (m * longint'({1'b0, s}) + 32768) >>> 16;
            return saturate(diff < 0 ? -r : r);
        endfunction

        function void note_input(logic [2:0] mode, logic signed [15:0] raw[3],
                                 logic signed [31:0] ld[3]);
            mag_result_t r;
            logic signed [31:0] v[3];
            longint sp[3], tot, sum, mid, den, q, s;
            bit bad;
            if (mode > MODE_LOAD_SCL) return;
            for (int i = 0; i < 3; i++) v[i] = offs[i];
            r.err = 0;
            case (mode)
                MODE_SAMPLE: begin
                    r.kind = KIND_SAMPLE;
                    for (int i = 0; i < 3; i++) begin
                        v[i] = gauss(raw[i]);
                        if (v[i] < tmin[i]) tmin[i] = v[i];
                        if (v[i] > tmax[i]) tmax[i] = v[i];
                    end
                    seen = 1;
                end
                MODE_FINISH: begin
                    r.kind = KIND_RESULT;
                    bad = !seen;
                    tot = 0;
                    for (int i = 0; i < 3; i++) begin
                        sp[i] = longint'(tmax[i]) - longint'(tmin[i]);
                        if (sp[i] <= 0) begin
                            bad = 1;
                            sp[i] = 0;
                        end
                        tot += sp[i];
                    end
                    if (!bad) begin
                        for (int i = 0; i < 3; i++) begin
                            sum = longint'(tmax[i]) + longint'(tmin[i]);
                            mid = sum >>> 1;
                            den = 3 * sp[i];
                            q = (tot * 65536 + den / 2) / den;
                            offs[i] = mid[31:0];
                            scl[i] = (q > 1048575) ? SCALE_MAX : q[19:0];
                        end
                    end
                    r.err = bad;
                    clear();
                    for (int i = 0; i < 3; i++) v[i] = offs[i];
                end
                MODE_CORRECT: begin
                    r.kind = KIND_CORRECTED;
                    for (int i = 0; i < 3; i++)
                        v[i] = corrected(gauss(raw[i]), offs[i], scl[i]);
                end
                MODE_LOAD_OFF: begin
                    r.kind = KIND_LOAD;
                    for (int i = 0; i < 3; i++) begin
                        offs[i] = ld[i];
                        v[i] = ld[i];
                    end
                end
                default: begin
                    r.kind = KIND_LOAD;
                    for (int i = 0; i < 3; i++) begin
                        s = ld[i];
                        if (s < 0) s = 0;
                        if (s > 1048575) s = 1048575;
                        scl[i] = s[19:0];
                    end
                end
            endcase
            r.x = v[0];
            r.y = v[1];
            r.z = v[2];
            r.sx = scl[0];
            r.sy = scl[1];
            r.sz = scl[2];
            pending.push_back(r);
        endfunction

        function void check_result(mag_result_t a);
            mag_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind %0d", $time, a.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, e.kind, a.kind); errors++;
            end
            if (a.x !== e.x) begin
                $display("%0t: out_x exp %h got %h", $time, e.x, a.x); errors++;
            end
            if (a.y !== e.y) begin
                $display("%0t: out_y exp %h got %h", $time, e.y, a.y); errors++;
            end
            if (a.z !== e.z) begin
                $display("%0t: out_z exp %h got %h", $time, e.z, a.z); errors++;
            end
            if (a.sx !== e.sx) begin
                $display("%0t: scale_x exp %h got %h", $time, e.sx, a.sx); errors++;
            end
            if (a.sy !== e.sy) begin
                $display("%0t: scale_y exp %h got %h", $time, e.sy, a.sy); errors++;
            end
            if (a.sz !== e.sz) begin
                $display("%0t: scale_z exp %h got %h", $time, e.sz, a.sz); errors++;
            end
            if (a.err !== e.err) begin
                $display("%0t: error exp %b got %b", $time, e.err, a.err); errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_mode = 0;
    logic [15:0] s_raw_x = 0, s_raw_y = 0, s_raw_z = 0;
    logic [31:0] s_load_x = 0, s_load_y = 0, s_load_z = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_kind;
    logic [31:0] m_out_x, m_out_y, m_out_z;
    logic [19:0] m_out_scale_x, m_out_scale_y, m_out_scale_z;
    logic        m_error;

    calib_scoreboard board;
    bit          no_idle = 0;
    longint      cycles = 0;

    magnetometer_iron_calibration u_dut (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000) begin
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        mag_result_t a;
        if (aresetn && m_valid && m_ready) begin
            a.kind = m_kind;
            a.x = m_out_x;
            a.y = m_out_y;
            a.z = m_out_z;
            a.sx = m_out_scale_x;
            a.sy = m_out_scale_y;
            a.sz = m_out_scale_z;
            a.err = m_error;
            board.check_result(a);
        end
        m_ready <= no_idle || ($urandom_range(99) >= 32);
    end

    task automatic apb_write(input logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 0;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        board.gain = value[2:0];
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic send(input logic [2:0] mode, input logic [15:0] rx, ry, rz,
                        input logic [31:0] lx, ly, lz);
        logic signed [15:0] raw[3];
        logic signed [31:0] ld[3];
        while (!no_idle && $urandom_range(99) < 32) @(posedge aclk);
        s_valid <= 1;
        s_mode <= mode;
        s_raw_x <= rx;
        s_raw_y <= ry;
        s_raw_z <= rz;
        s_load_x <= lx;
        s_load_y <= ly;
        s_load_z <= lz;
        raw = '{rx, ry, rz};
        ld = '{lx, ly, lz};
        do @(posedge aclk); while (!s_ready);
        board.note_input(mode, raw, ld);
        s_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_raw();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(2000) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_load();
        case ($urandom_range(4))
            0: return $urandom_range(1048575);
            1: return 32'h80000000;
            2: return 32'h7FFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        int p;
        p = $urandom_range(99);
        if (p < 55) send(MODE_SAMPLE, rand_raw(), rand_raw(), rand_raw(),
                         $urandom, $urandom, $urandom);
        else if (p < 65) send(MODE_FINISH, 16'($urandom), 16'($urandom), 16'($urandom),
                              $urandom, $urandom, $urandom);
        else if (p < 88) send(MODE_CORRECT, rand_raw(), rand_raw(), rand_raw(),
                              $urandom, $urandom, $urandom);
        else if (p < 93) send(MODE_LOAD_OFF, 16'($urandom), 16'($urandom), 16'($urandom),
                              rand_load(), rand_load(), rand_load());
        else if (p < 97) send(MODE_LOAD_SCL, 16'($urandom), 16'($urandom), 16'($urandom),
                              rand_load(), rand_load(), rand_load());
        else send(3'(5 + $urandom_range(2)), 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom, $urandom, $urandom);
    endtask

    initial begin
        board = new();
        board.init();
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send(MODE_FINISH, 0, 0, 0, 0, 0, 0);
        send(MODE_CORRECT, 16'h7FFF, 16'h8000, 16'h0000, 0, 0, 0);
        send(MODE_SAMPLE, 16'h7FFF, 16'h8000, 16'h0001, 0, 0, 0);
        send(MODE_FINISH, 0, 0, 0, 0, 0, 0);
        send(MODE_SAMPLE, 16'h8000, 16'h7FFF, 16'hFFFF, 0, 0, 0);
        send(MODE_SAMPLE, 16'h7FFF, 16'h8000, 16'h0001, 0, 0, 0);
        send(MODE_FINISH, 0, 0, 0, 0, 0, 0);
        send(MODE_CORRECT, 16'h7FFF, 16'h8000, 16'h0123, 0, 0, 0);
        send(MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0);
        send(MODE_SAMPLE, 16'h0001, 16'h7000, 16'h0000, 0, 0, 0);
        send(MODE_FINISH, 0, 0, 0, 0, 0, 0);
        send(MODE_LOAD_OFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send(MODE_LOAD_SCL, 0, 0, 0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h000FFFFF);
        send(MODE_CORRECT, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0);
        send(3'd5, 0, 0, 0, 0, 0, 0);
        send(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(MODE_LOAD_SCL, 0, 0, 0, 32'h00010000, 32'h00020000, 32'h00008000);
        send(MODE_LOAD_OFF, 0, 0, 0, 0, 32'h00001000, 32'hFFFFF000);
        for (int g = 0; g < 8; g++) begin
            drain();
            apb_write((g == 7) ? 32'hFFFFFFF8 | g : g);
            if (g == 3) no_idle = 1;
            for (int n = 0; n < 100; n++) random_item();
            no_idle = 0;
        end
        drain();
        apb_write(0);
        for (int n = 0; n < 30; n++) random_item();
        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

### magnetometer_iron_calibration.f
hdl/mic_pkg.sv
hdl/mic_divider.sv
hdl/mic_lane.sv
hdl/magnetometer_iron_calibration.sv
hdl/mic_checker.sv
test/testbench.sv
